/* rtl/core/fat12_cluster_chain_walker_top_assert.svh */
// Assertion macros for the FAT12 cluster chain walker checker
`ifndef FAT12_CLUSTER_CHAIN_WALKER_TOP_ASSERT_SVH
`define FAT12_CLUSTER_CHAIN_WALKER_TOP_ASSERT_SVH

// check that cons holds in the same cycle as ante
`define FCW_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// check that cons holds in the cycle after ante
`define FCW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/fcw_pkg.sv */
// Types and constants shared by the FAT12 cluster chain walker files
package fcw_pkg;

  localparam logic [1:0] KIND_LOAD    = 2'd0;
  localparam logic [1:0] KIND_START   = 2'd1;
  localparam logic [1:0] KIND_ADVANCE = 2'd2;

  localparam logic [1:0] ST_STORED   = 2'd0;
  localparam logic [1:0] ST_SECTOR   = 2'd1;
  localparam logic [1:0] ST_WALK_END = 2'd2;
  localparam logic [1:0] ST_OOR      = 2'd3;

  localparam logic [11:0] CHAIN_END          = 12'hFF8;
  localparam logic [11:0] ENTRY_MASK         = 12'hFFF;
  localparam logic [11:0] FIRST_DATA_CLUSTER = 12'd2;
  localparam logic [15:0] DATA_START_RESET   = 16'd33;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] sector_lba;
    logic [9:0]  sector_bytes;
    logic        final_res;
  } result_t;

  typedef enum logic [1:0] {
    SRC_IMM,
    SRC_READ,
    SRC_HELD
  } src_e;

  typedef struct packed {
    logic accept;
    logic mem_step;
    logic load_out;
    src_e src;
  } dp_cmd_t;

  typedef struct packed {
    logic need_read;
  } dp_stat_t;

endpackage

/* rtl/core/fcw_if.sv */
// Input and result channel interfaces of the FAT12 cluster chain walker
interface fcw_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [12:0] table_address;
  logic [7:0]  table_byte;
  logic [11:0] start_cluster;
  logic [31:0] file_length;

  modport source (output valid, kind, table_address, table_byte, start_cluster,
                  file_length, input ready);
  modport sink (input valid, kind, table_address, table_byte, start_cluster,
                file_length, output ready);
endinterface

interface fcw_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [15:0] sector_lba;
  logic [9:0]  sector_bytes;
  logic        final_res;

  modport source (output valid, status, sector_lba, sector_bytes, final_res,
                  input ready);
  modport sink (input valid, status, sector_lba, sector_bytes, final_res,
                output ready);
endinterface

/* rtl/core/fat12_cluster_chain_walker_top.sv */
// Top level of the FAT12 cluster chain walker
//
//  channel  | dir | handshake        | payload
//  ---------+-----+------------------+--------------------------------------------------
//  in_if    | in  | valid / ready    | kind, table_address, table_byte, start_cluster,
//           |     |                  | file_length
//  out_if   | out | valid / ready    | status, sector_lba, sector_bytes, final_res
//  cfg      | in  | cfg_we_i         | cfg_wdata_i (data_start_sector)
//
// Loads, walk ends and steps that need no table read finish in the transfer cycle if the
// output slot is free. A step that follows the chain reads the table byte pair from the
// two-port store in the transfer cycle and forms the next cluster the cycle after.
// A new transfer is taken whenever the controller is idle, even while a result waits.
// Reset clears the walk state and sets the data start to 33; the table is not cleared.
// A stalled result holds in the output register; further results wait in a hold stage.
module fat12_cluster_chain_walker_top import fcw_pkg::*; #(
  parameter int unsigned TABLE_BYTES  = 6144,
  parameter int unsigned SECTOR_BYTES = 512
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  fcw_in_if.sink      in_if,
  fcw_out_if.source   out_if,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i
);

  dp_cmd_t  cmd;
  dp_stat_t stat;
  result_t  res;
  logic     in_ready;
  logic     out_valid;

  fcw_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_if.valid),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .out_ready_i (out_if.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  fcw_datapath #(
    .TABLE_BYTES  (TABLE_BYTES),
    .SECTOR_BYTES (SECTOR_BYTES)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .kind_i          (in_if.kind),
    .table_address_i (in_if.table_address),
    .table_byte_i    (in_if.table_byte),
    .start_cluster_i (in_if.start_cluster),
    .file_length_i   (in_if.file_length),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .res_o           (res)
  );

  assign in_if.ready         = in_ready;
  assign out_if.valid        = out_valid;
  assign out_if.status       = res.status;
  assign out_if.sector_lba   = res.sector_lba;
  assign out_if.sector_bytes = res.sector_bytes;
  assign out_if.final_res    = res.final_res;

endmodule

/* rtl/core/fcw_ctrl.sv */
// Controller state machine: sequences transfers, table reads and result loads
module fcw_ctrl import fcw_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_EMIT
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   slot_free;

  assign slot_free  = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d        = state_q;
    cmd_o.accept   = 1'b0;
    cmd_o.mem_step = 1'b0;
    cmd_o.load_out = 1'b0;
    cmd_o.src      = SRC_HELD;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          if (stat_i.need_read) begin
            state_d = S_READ;
          end else if (slot_free) begin
            cmd_o.load_out = 1'b1;
            cmd_o.src      = SRC_IMM;
          end else begin
            state_d = S_EMIT;
          end
        end
      end
      S_READ: begin
        cmd_o.mem_step = 1'b1;
        cmd_o.src      = SRC_READ;
        if (slot_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end else begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (slot_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

/* rtl/core/fcw_datapath.sv */
// Datapath: allocation table store, walk registers, sector arithmetic, result registers
module fcw_datapath import fcw_pkg::*; #(
  parameter int unsigned TABLE_BYTES  = 6144,
  parameter int unsigned SECTOR_BYTES = 512
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  dp_cmd_t     cmd_i,
  output dp_stat_t    stat_o,
  input  logic [1:0]  kind_i,
  input  logic [12:0] table_address_i,
  input  logic [7:0]  table_byte_i,
  input  logic [11:0] start_cluster_i,
  input  logic [31:0] file_length_i,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  output result_t     res_o
);

  localparam int unsigned AW  = $clog2(TABLE_BYTES);
  localparam int unsigned NBW = $clog2(SECTOR_BYTES + 1);

  function automatic logic is_end_mark(input logic [11:0] c);
    return (c < FIRST_DATA_CLUSTER) || (c >= CHAIN_END);
  endfunction

  logic [7:0]  mem [TABLE_BYTES];
  logic [7:0]  rd0_q, rd1_q;
  logic        odd_q;
  logic [15:0] data_start_q;
  logic [11:0] cluster_q;
  logic [31:0] remaining_q;
  logic        walking_q;
  result_t     res_q, out_q, imm_res, read_res;

  logic            is_start, is_walk, wk, end_w, part_sector, last, oor, need_read;
  logic [11:0]     c;
  logic [31:0]     rem, rem_next;
  logic [NBW-1:0]  nbytes;
  logic [NBW+9:0]  nb_ext;
  logic [12:0]     off;
  logic [13:0]     off_nx;
  logic [15:0]     lba;
  logic [15:0]     pair;
  logic [11:0]     next_c;
  logic            next_end;

  assign is_start = (kind_i == KIND_START);
  assign is_walk  = is_start || (kind_i == KIND_ADVANCE);
  assign c        = is_start ? start_cluster_i : cluster_q;
  assign rem      = is_start ? file_length_i : remaining_q;
  assign wk       = is_start || walking_q;
  assign end_w    = !wk || is_end_mark(c) || (rem == 32'd0);

  assign part_sector = rem < 32'(SECTOR_BYTES);
  assign nbytes      = part_sector ? rem[NBW-1:0] : NBW'(SECTOR_BYTES);
  assign rem_next    = rem - {{(32-NBW){1'b0}}, nbytes};
  assign last        = (rem_next == 32'd0);
  assign nb_ext      = {10'd0, nbytes};

  assign off    = {1'b0, c} + {2'b00, c[11:1]};
  assign off_nx = {1'b0, off} + 14'd1;
  assign oor    = off_nx >= 14'(TABLE_BYTES);
  assign lba    = data_start_q + {4'd0, c} - {4'd0, FIRST_DATA_CLUSTER};

  assign need_read        = is_walk && !end_w && !last && !oor;
  assign stat_o.need_read = need_read;

  always_comb begin
    imm_res.status       = ST_WALK_END;
    imm_res.sector_lba   = 16'd0;
    imm_res.sector_bytes = 10'd0;
    imm_res.final_res    = !walking_q;
    case (kind_i)
      KIND_LOAD: begin
        imm_res.status = ST_STORED;
      end
      KIND_START, KIND_ADVANCE: begin
        imm_res.final_res = 1'b1;
        if (end_w) begin
          imm_res.status = ST_WALK_END;
        end else if (oor && !last) begin
          imm_res.status = ST_OOR;
        end else begin
          imm_res.status       = ST_SECTOR;
          imm_res.sector_lba   = lba;
          imm_res.sector_bytes = nb_ext[9:0];
          imm_res.final_res    = last;
        end
      end
      default: begin
        imm_res.status = ST_WALK_END;
      end
    endcase
  end

  assign pair     = {rd1_q, rd0_q};
  assign next_c   = (odd_q ? pair[15:4] : pair[11:0]) & ENTRY_MASK;
  assign next_end = is_end_mark(next_c);

  always_comb begin
    read_res           = res_q;
    read_res.final_res = next_end;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && (kind_i == KIND_LOAD) && (table_address_i < 13'(TABLE_BYTES))) begin
      mem[table_address_i[AW-1:0]] <= table_byte_i;
    end
    if (cmd_i.accept && need_read) begin
      rd0_q <= mem[off[AW-1:0]];
      rd1_q <= mem[off_nx[AW-1:0]];
      odd_q <= c[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_start_q <= DATA_START_RESET;
      cluster_q    <= 12'd0;
      remaining_q  <= 32'd0;
      walking_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        data_start_q <= cfg_wdata_i;
      end
      if (cmd_i.accept && is_walk) begin
        cluster_q <= c;
        if (end_w) begin
          remaining_q <= rem;
          walking_q   <= 1'b0;
        end else begin
          remaining_q <= rem_next;
          walking_q   <= need_read;
        end
      end
      if (cmd_i.mem_step) begin
        cluster_q <= next_c;
        walking_q <= !next_end;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      res_q <= imm_res;
    end else if (cmd_i.mem_step) begin
      res_q <= read_res;
    end
    if (cmd_i.load_out) begin
      case (cmd_i.src)
        SRC_IMM:  out_q <= imm_res;
        SRC_READ: out_q <= read_res;
        default:  out_q <= res_q;
      endcase
    end
  end

  assign res_o = out_q;

endmodule

/* rtl/core/fcw_checker.sv */
// Port-level assertion checker for the FAT12 cluster chain walker, with its bind
`include "fat12_cluster_chain_walker_top_assert.svh"

module fcw_checker import fcw_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [1:0]  status_i,
  input logic [15:0] sector_lba_i,
  input logic [9:0]  sector_bytes_i,
  input logic        final_res_i
);

  `FCW_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i && $stable(status_i) && $stable(sector_lba_i) && $stable(sector_bytes_i) && $stable(final_res_i), "result changed while stalled")
  `FCW_ASSERT_NOW(a_store_zero, out_valid_i && (status_i == ST_STORED), (sector_lba_i == 16'd0) && (sector_bytes_i == 10'd0), "store result carries sector data")
  `FCW_ASSERT_NOW(a_end_final, out_valid_i && ((status_i == ST_OOR) || ((status_i == ST_WALK_END) && final_res_i)), final_res_i && (sector_lba_i == 16'd0) && (sector_bytes_i == 10'd0), "walk end result malformed")
  `FCW_ASSERT_NOW(a_sector_bytes, out_valid_i && (status_i == ST_SECTOR), sector_bytes_i != 10'd0, "sector result with no bytes")

endmodule

bind fat12_cluster_chain_walker_top fcw_checker u_fcw_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (out_if.valid),
  .out_ready_i    (out_if.ready),
  .status_i       (out_if.status),
  .sector_lba_i   (out_if.sector_lba),
  .sector_bytes_i (out_if.sector_bytes),
  .final_res_i    (out_if.final_res)
);
